### sv/bsl_pkg.sv
// Shared types, codes and defaults for the bounded sorted list.
package bsl_pkg;

	localparam int MAX_ENTRIES_DEF = 16;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int CAP_W           = 5;
	localparam int POS_W           = 5;
	localparam int DATA_W          = 32;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_POP    = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_FULL   = 2'd1,
		STAT_EMPTY  = 2'd2,
		STAT_BADPOS = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_CMP,
		S_INS_LAST,
		S_TAKE,
		S_SHIFT,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic             is_empty;
		logic             is_full;
		logic [POS_W-1:0] entry_count;
		logic [DATA_W-1:0] result_value;
		status_t          status;
	} rsp_t;

endpackage

### sv/bounded_sorted_list.sv
// Bounded sorted list: top level with capacity register and output word register.
//
// A command word enters on the s_ group (kind on s_tuser: 0 insert, 1 pop front,
// 2 remove at position, 3 read at position; value and 1-based position on
// s_tdata). Each command gives exactly one response word on the m_ group with
// status, the value popped/removed/read, the entry count and full/empty flags.
// The user must write the capacity register over cfg_valid/cfg_ready/cfg_data only
// while idle; the block itself does not enforce it. One command is worked at a time;
// s_tready is high only while the sequencer idles. A refused command (full, empty,
// bad position) goes straight to its response; an insert into an empty list writes
// the entry directly; any other insert walks down from the last entry, moving each
// entry greater than the new value up one place, then writes the new value; read
// takes the entry at the position; pop and remove take the entry, then shift the
// entries behind the gap down one place. The walk over the entry store goes one
// entry a cycle, with read data registered in the store.
// Responses sit in an output register; if the receiver stalls, the sequencer
// holds its finished response and the next command waits until the word is taken.
// Reset empties the list and sets capacity to 10; entry contents are not cleared.
module bounded_sorted_list #(
	parameter int MAX_ENTRIES = bsl_pkg::MAX_ENTRIES_DEF,
	parameter int VALUE_WIDTH = bsl_pkg::VALUE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data,   // capacity
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,    // value[31:0], position[36:32], zero fill
	input  logic [1:0]  s_tuser,    // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata     // status[1:0], result_value[33:2], entry_count[38:34],
	                                // is_full[39], is_empty[40], zero fill
);
	import bsl_pkg::*;

	logic [CAP_W-1:0] cap_q;
	logic             m_tvalid_q;
	rsp_t             m_word_q;
	rsp_t             rsp;
	logic             rsp_valid, rsp_free;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	assign rsp_free = !m_tvalid_q || m_tready;

	bsl_ctrl #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.capacity  (cap_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (cmd_t'(s_tuser)),
		.in_value  (s_tdata[31:0]),
		.in_pos    (s_tdata[36:32]),
		.rsp_valid (rsp_valid),
		.rsp_free  (rsp_free),
		.rsp       (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (rsp_free) begin
			m_tvalid_q <= rsp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_valid && rsp_free) begin
			m_word_q <= rsp;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, m_word_q};

endmodule

### sv/bsl_mem.sv
// Entry store: one write port, one read port with registered read data.
module bsl_mem #(
	parameter int DEPTH = bsl_pkg::MAX_ENTRIES_DEF,
	parameter int WIDTH = bsl_pkg::VALUE_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### sv/bsl_ctrl.sv
// Sequencer: walks the entry store one entry a cycle through a single signed comparator.
module bsl_ctrl #(
	parameter int MAX_ENTRIES = bsl_pkg::MAX_ENTRIES_DEF,
	parameter int VALUE_WIDTH = bsl_pkg::VALUE_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [bsl_pkg::CAP_W-1:0]   capacity,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  bsl_pkg::cmd_t               in_cmd,
	input  logic [bsl_pkg::DATA_W-1:0]  in_value,
	input  logic [bsl_pkg::POS_W-1:0]   in_pos,
	output logic                        rsp_valid,
	input  logic                        rsp_free,
	output bsl_pkg::rsp_t               rsp
);
	import bsl_pkg::*;

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int XW = ((CW > CAP_W) ? CW : CAP_W) + 1;

	state_t                 state_q, state_d;
	cmd_t                   cmd_q, cmd_d;
	status_t                stat_q, stat_d;
	logic [VALUE_WIDTH-1:0] val_q, val_d;
	logic [VALUE_WIDTH-1:0] res_q, res_d;
	logic [AW-1:0]          idx_q, idx_d;
	logic [CW-1:0]          cnt_q, cnt_d;

	logic                   we, re;
	logic [AW-1:0]          waddr, raddr;
	logic [VALUE_WIDTH-1:0] wdata, rdata;
	logic [VALUE_WIDTH-1:0] in_val;
	logic [XW-1:0]          cap_x, max_x, cap_eff, cnt_x, idx_x;
	logic                   full_c, pos_bad, greater;

	bsl_mem #(
		.DEPTH (MAX_ENTRIES),
		.WIDTH (VALUE_WIDTH)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign in_val  = VALUE_WIDTH'($signed(in_value));
	assign cap_x   = XW'(capacity);
	assign max_x   = XW'(MAX_ENTRIES);
	assign cap_eff = (cap_x > max_x) ? max_x : cap_x;
	assign cnt_x   = XW'(cnt_q);
	assign idx_x   = XW'(idx_q);
	assign full_c  = (cnt_x >= cap_eff);
	assign pos_bad = (in_pos == '0) || (XW'(in_pos) > cnt_x);
	// the one comparator: stored entry against the value being inserted
	assign greater = ($signed(rdata) > $signed(val_q));

	assign in_ready  = (state_q == S_IDLE);
	assign rsp_valid = (state_q == S_FINISH);

	always_comb begin
		rsp.status       = stat_q;
		rsp.result_value = DATA_W'($signed(res_q));
		rsp.entry_count  = POS_W'(cnt_q);
		rsp.is_full      = full_c;
		rsp.is_empty     = (cnt_q == '0);
	end

	always_comb begin
		state_d = state_q;
		cmd_d   = cmd_q;
		stat_d  = stat_q;
		val_d   = val_q;
		res_d   = res_q;
		idx_d   = idx_q;
		cnt_d   = cnt_q;
		we      = 1'b0;
		waddr   = idx_q;
		wdata   = val_q;
		re      = 1'b0;
		raddr   = idx_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd_d  = in_cmd;
					val_d  = in_val;
					res_d  = '0;
					stat_d = STAT_OK;
					case (in_cmd)
						CMD_INSERT: begin
							if (full_c) begin
								stat_d  = STAT_FULL;
								state_d = S_FINISH;
							end else if (cnt_q == '0) begin
								we      = 1'b1;
								waddr   = '0;
								wdata   = in_val;
								cnt_d   = cnt_q + 1'b1;
								state_d = S_FINISH;
							end else begin
								idx_d   = AW'(cnt_q);
								re      = 1'b1;
								raddr   = AW'(cnt_q - 1'b1);
								state_d = S_INS_CMP;
							end
						end
						default: begin
							if (cnt_q == '0) begin
								stat_d  = STAT_EMPTY;
								state_d = S_FINISH;
							end else if (in_cmd == CMD_POP) begin
								idx_d   = '0;
								re      = 1'b1;
								raddr   = '0;
								state_d = S_TAKE;
							end else if (pos_bad) begin
								stat_d  = STAT_BADPOS;
								state_d = S_FINISH;
							end else begin
								idx_d   = AW'(in_pos - 1'b1);
								re      = 1'b1;
								raddr   = AW'(in_pos - 1'b1);
								state_d = S_TAKE;
							end
						end
					endcase
				end
			end
			S_INS_CMP: begin
				// rdata holds entry idx-1; move it up or drop the new value in
				we = 1'b1;
				if (greater) begin
					wdata = rdata;
					idx_d = idx_q - 1'b1;
					if (idx_q == AW'(1)) begin
						state_d = S_INS_LAST;
					end else begin
						re    = 1'b1;
						raddr = idx_q - AW'(2);
					end
				end else begin
					cnt_d   = cnt_q + 1'b1;
					state_d = S_FINISH;
				end
			end
			S_INS_LAST: begin
				we      = 1'b1;
				waddr   = '0;
				cnt_d   = cnt_q + 1'b1;
				state_d = S_FINISH;
			end
			S_TAKE: begin
				res_d = rdata;
				if (cmd_q == CMD_READ) begin
					state_d = S_FINISH;
				end else if (idx_x + XW'(1) < cnt_x) begin
					re      = 1'b1;
					raddr   = idx_q + 1'b1;
					state_d = S_SHIFT;
				end else begin
					cnt_d   = cnt_q - 1'b1;
					state_d = S_FINISH;
				end
			end
			S_SHIFT: begin
				// close the gap: word at idx+1 moves down to idx
				we    = 1'b1;
				wdata = rdata;
				idx_d = idx_q + 1'b1;
				if (idx_x + XW'(2) < cnt_x) begin
					re    = 1'b1;
					raddr = idx_q + AW'(2);
				end else begin
					cnt_d   = cnt_q - 1'b1;
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (rsp_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q  <= cmd_d;
		stat_q <= stat_d;
		val_q  <= val_d;
		res_q  <= res_d;
		idx_q  <= idx_d;
	end

endmodule

### test/sorted_list_checker.sv
// Checker for the bounded sorted list: tracks the list, predicts each response word and compares.
module sorted_list_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [4:0]  cfg_data,   // capacity
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,    // value[31:0], position[36:32], zero fill
	input  logic [1:0]  s_tuser,    // cmd[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,    // status, result_value, entry_count, is_full, is_empty
	output int          outstanding,
	output int          failures
);
	import bsl_pkg::*;

	localparam int DEPTH      = MAX_ENTRIES_DEF;
	localparam int SHOW_LIMIT = 40;

	logic signed [DATA_W-1:0] held [DEPTH];
	int unsigned              held_cnt;
	logic [CAP_W-1:0]         capacity;
	rsp_t                     expected_rsp [$];
	int                       fail_cnt;

	// capacities above the store depth behave as the depth
	function automatic int unsigned eff_capacity();
		return (capacity > DEPTH) ? DEPTH : capacity;
	endfunction

	function automatic logic [DATA_W-1:0] take_entry(int unsigned idx);
		logic [DATA_W-1:0] v;
		v = held[idx];
		for (int unsigned k = idx; k + 1 < held_cnt; k++)
			held[k] = held[k+1];
		held_cnt--;
		return v;
	endfunction

	function automatic rsp_t apply_command(cmd_t cmd, logic signed [DATA_W-1:0] val,
			logic [POS_W-1:0] pos);
		rsp_t        r;
		int unsigned k;
		r = '0;
		r.status = STAT_OK;
		if (cmd == CMD_INSERT) begin
			if (held_cnt >= eff_capacity()) begin
				r.status = STAT_FULL;
			end else begin
				// equal values: new one goes behind the existing ones
				k = held_cnt;
				while (k > 0 && held[k-1] > val) begin
					held[k] = held[k-1];
					k--;
				end
				held[k] = val;
				held_cnt++;
			end
		end else if (held_cnt == 0) begin
			r.status = STAT_EMPTY;
		end else if (cmd == CMD_POP) begin
			r.result_value = take_entry(0);
		end else if (pos == 0 || pos > held_cnt) begin
			r.status = STAT_BADPOS;
		end else if (cmd == CMD_REMOVE) begin
			r.result_value = take_entry(pos - 1);
		end else begin
			r.result_value = held[pos-1];
		end
		r.entry_count = POS_W'(held_cnt);
		r.is_full     = (held_cnt >= eff_capacity());
		r.is_empty    = (held_cnt == 0);
		return r;
	endfunction

	function automatic void check_field(string name, logic [DATA_W-1:0] want,
			logic [DATA_W-1:0] got);
		if (want !== got) begin
			fail_cnt++;
			if (fail_cnt <= SHOW_LIMIT)
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t got;
		rsp_t want;
		if (!arst_n) begin
			held_cnt = 0;
			capacity = CAP_RESET;
			expected_rsp.delete();
			fail_cnt = 0;
			outstanding <= 0;
			failures <= 0;
		end else begin
			// response word first: it always belongs to an earlier command
			if (m_tvalid && m_tready) begin
				got = rsp_t'(m_tdata[40:0]);
				if (expected_rsp.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= SHOW_LIMIT)
						$display("%0t: unexpected response word, expected none, got %0h",
							$time, m_tdata);
				end else begin
					want = expected_rsp.pop_front();
					check_field("status", DATA_W'(want.status), DATA_W'(got.status));
					check_field("result_value", want.result_value, got.result_value);
					check_field("entry_count", DATA_W'(want.entry_count),
						DATA_W'(got.entry_count));
					check_field("is_full", DATA_W'(want.is_full), DATA_W'(got.is_full));
					check_field("is_empty", DATA_W'(want.is_empty), DATA_W'(got.is_empty));
				end
			end
			if (cfg_valid && cfg_ready)
				capacity = cfg_data;
			if (s_tvalid && s_tready)
				expected_rsp.push_back(apply_command(cmd_t'(s_tuser), s_tdata[31:0],
					s_tdata[36:32]));
			outstanding <= expected_rsp.size();
			failures <= fail_cnt;
		end
	end

endmodule

### test/tb_bounded_sorted_list.sv
// Testbench top for the bounded sorted list: stimulus, handshake pacing and verdict.
module tb_bounded_sorted_list;
	import bsl_pkg::*;

	localparam int RUN_ITEMS   = 1950;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_MAX    = 6;

	localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [4:0]  cfg_data = CAP_RESET;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;      // value[31:0], position[36:32], zero fill
	logic [1:0]  s_tuser = CMD_INSERT;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	int          outstanding;
	int          failures;
	int          cycles = 0;
	bit          no_idle = 1'b0;
	int unsigned ready_hold = 0;
	int          cmd_sent [4] = '{0, 0, 0, 0};
	int          cap_writes = 0;

	always #6 clk = ~clk;

	bounded_sorted_list i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	sorted_list_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.outstanding (outstanding),
		.failures    (failures)
	);

	// receiver: after each taken word, hold ready low for a random number of cycles
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			ready_hold = no_idle ? 0 : $urandom_range(0, HOLD_MAX);
			m_tready <= (ready_hold == 0);
		end else if (ready_hold != 0) begin
			ready_hold--;
			m_tready <= (ready_hold == 0);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb: failure");
			$finish;
		end
	end

	// valid stays high across back-to-back words; send_cmd lowers it only when a gap is drawn
	task automatic send_cmd(cmd_t cmd, logic signed [31:0] val, logic [4:0] pos);
		int unsigned gap;
		gap = no_idle ? 0 : $urandom_range(0, HOLD_MAX);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {3'b000, pos, val};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		cmd_sent[cmd]++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_capacity(logic [4:0] cap);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= cap;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		cap_writes++;
	endtask

	function automatic logic signed [31:0] rand_value();
		case ($urandom_range(0, 3))
			0: return $signed($urandom_range(0, 8)) - 4;   // many equal values
			1: begin
				case ($urandom_range(0, 3))
					0: return VAL_MIN;
					1: return VAL_MAX;
					2: return 0;
					default: return -1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [4:0] rand_pos();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		else if (r < 55)
			return 5'($urandom_range(1, 4));
		else
			return 5'($urandom_range(1, 16));
	endfunction

	initial begin
		logic [4:0]  cap_list [10];
		int          random_sent;
		int          phase;
		int          phase_len;
		int unsigned ins_pct;
		int unsigned r;
		cmd_t        cmd;

		cap_list = '{16, 0, 1, 31, 2, 10, 17, 5, 16, 3};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list, reset capacity
		send_cmd(CMD_POP, 0, 0);
		send_cmd(CMD_READ, 0, 16);
		send_cmd(CMD_REMOVE, 0, 5);
		send_cmd(CMD_INSERT, 0, 0);
		send_cmd(CMD_INSERT, VAL_MIN, 0);
		send_cmd(CMD_INSERT, VAL_MAX, 16);
		send_cmd(CMD_INSERT, -1, 0);
		send_cmd(CMD_INSERT, 0, 0);
		send_cmd(CMD_READ, 0, 0);
		send_cmd(CMD_READ, 0, 6);
		send_cmd(CMD_READ, 0, 5);
		send_cmd(CMD_READ, 0, 1);
		send_cmd(CMD_REMOVE, 0, 5);
		send_cmd(CMD_REMOVE, 0, 2);
		send_cmd(CMD_POP, 0, 0);
		write_capacity(2);
		send_cmd(CMD_INSERT, 5, 0);
		// zero capacity: always full
		write_capacity(0);
		send_cmd(CMD_INSERT, -7, 0);
		send_cmd(CMD_READ, 0, 1);
		// capacity below the current count
		write_capacity(1);
		send_cmd(CMD_INSERT, 1, 0);
		send_cmd(CMD_POP, 0, 0);
		send_cmd(CMD_INSERT, 2, 0);
		write_capacity(31);
		send_cmd(CMD_INSERT, 7, 0);
		send_cmd(CMD_REMOVE, 0, 16);

		// random phases alternate fill-heavy and drain-heavy mixes
		random_sent = 0;
		phase = 0;
		while (random_sent < RUN_ITEMS) begin
			write_capacity(phase < 10 ? cap_list[phase] : 5'($urandom_range(0, 31)));
			no_idle <= (phase % 4 == 3);
			ins_pct = (phase % 2 == 0) ? 70 : 30;
			phase_len = $urandom_range(40, 120);
			for (int i = 0; i < phase_len && random_sent < RUN_ITEMS; i++) begin
				if ($urandom_range(0, 49) == 0)
					drain();
				r = $urandom_range(0, 99);
				if (r < ins_pct) begin
					cmd = CMD_INSERT;
				end else begin
					case (r % 3)
						0: cmd = CMD_POP;
						1: cmd = CMD_REMOVE;
						default: cmd = CMD_READ;
					endcase
				end
				send_cmd(cmd, rand_value(), rand_pos());
				random_sent++;
			end
			phase++;
		end

		drain();
		repeat (30) @(posedge clk);
		$display("summary: %0d inserts, %0d pops, %0d removes, %0d reads over %0d phases",
			cmd_sent[CMD_INSERT], cmd_sent[CMD_POP], cmd_sent[CMD_REMOVE],
			cmd_sent[CMD_READ], phase);
		$display("summary: %0d capacity writes, %0d mismatches, %0d words still expected",
			cap_writes, failures, outstanding);
		if (failures == 0 && outstanding == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
